[sv/mxinv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxinv_pkg
// Shared types, widths and the cofactor addressing function of the 4x4
// matrix inverse.
// ----------------------------------------------------------------------------
package mxinv_pkg;

	localparam int DATA_WIDTH   = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIG          = 16;

	localparam logic [3:0] LAST_INDEX = 4'd15;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] element_value;
		logic [3:0]                   element_index;
	} element_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] inverse_value;
		logic [3:0]                   out_index;
		logic                         singular;
		logic                         saturated;
		logic                         last_result;
	} result_t;

	// store address of factor k of triple tr of cofactor ci = {row, col}
	function automatic logic [3:0] elem_addr(input logic [3:0] ci, input logic [2:0] tr,
		input logic [1:0] k);
		logic [1:0] pc;
		logic [1:0] row;
		logic [1:0] col;
		case (tr)
			3'd0: pc = k;
			3'd1: pc = (k == 2'd2) ? 2'd0 : k + 2'd1;
			3'd2: pc = (k == 2'd0) ? 2'd2 : k - 2'd1;
			3'd3: pc = (k == 2'd0) ? 2'd0 : ((k == 2'd1) ? 2'd2 : 2'd1);
			3'd4: pc = (k == 2'd0) ? 2'd1 : ((k == 2'd1) ? 2'd0 : 2'd2);
			default: pc = 2'd2 - k;
		endcase
		row = (k < ci[3:2]) ? k : k + 2'd1;
		col = (pc < ci[1:0]) ? pc : pc + 2'd1;
		return {row, col};
	endfunction

endpackage

[sv/mxinv_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxinv_mul
// Digit-serial unsigned multiplier: one DIG-bit digit of y per cycle,
// most significant digit first.
// ----------------------------------------------------------------------------
module mxinv_mul import mxinv_pkg::*; #(
	parameter int MW   = 64,
	parameter int YW   = 112,
	parameter int CNTW = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MW-1:0]       m,
	input  logic [YW-1:0]       y,
	input  logic [CNTW-1:0]     top_dig,
	output logic                done,
	output logic [MW+YW-1:0]    p
);

	localparam int PW = MW + YW;

	logic              run_q;
	logic              done_q;
	logic [CNTW-1:0]   cnt_q;
	logic [MW-1:0]     m_q;
	logic [YW-1:0]     y_q;
	logic [PW-1:0]     p_q;
	logic [DIG-1:0]    dig;
	logic [MW+DIG-1:0] prod;

	assign dig  = y_q[cnt_q*DIG +: DIG];
	assign prod = m_q * dig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= top_dig;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= m;
			y_q <= y;
			p_q <= '0;
		end else if (run_q) begin
			p_q <= (p_q << DIG) + PW'(prod);
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

[sv/mxinv_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxinv_div
// Restoring divider: overflow check on the high part, then one quotient bit
// per cycle for the low QW bits.
// ----------------------------------------------------------------------------
module mxinv_div #(
	parameter int NW  = 130,
	parameter int DEW = 132,
	parameter int QW  = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   num,
	input  logic [DEW-1:0]  den,
	output logic            done,
	output logic            ovf,
	output logic [QW-1:0]   quo
);

	localparam int RW = DEW + 1;
	localparam int CW = $clog2(QW + 1);

	logic            run_q;
	logic            chk_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic            ovf_q;
	logic [RW-1:0]   r_q;
	logic [QW-1:0]   nl_q;
	logic [QW-1:0]   q_q;
	logic [DEW-1:0]  d_q;
	logic [RW-1:0]   rs;
	logic            ge;

	assign rs = {r_q[RW-2:0], nl_q[QW-1]};
	assign ge = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				chk_q <= 1'b1;
				cnt_q <= CW'(QW);
				ovf_q <= 1'b0;
			end else if (run_q && chk_q) begin
				chk_q <= 1'b0;
				if (r_q >= {1'b0, d_q}) begin
					ovf_q  <= 1'b1;
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= RW'(num >> QW);
			nl_q <= num[QW-1:0];
			d_q  <= den;
			q_q  <= '0;
		end else if (run_q && !chk_q) begin
			r_q  <= ge ? rs - {1'b0, d_q} : rs;
			nl_q <= nl_q << 1;
			q_q  <= {q_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = q_q;

endmodule

[sv/matrix_inverse_4x4.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 inverse by adjugate: elements kept in a 16-entry memory, cofactors
// built by a digit-serial multiplier into a second memory, results by a
// restoring divider.
// Flow: an element with index 0..14 is stored and busy stays low.
// Index 15 runs 96 triples (three reads and two two-digit multiplies each)
// plus 16 cofactor writes, four multiplies for the determinant, one check
// and, unless the determinant is zero, 16 divisions; busy is high
// throughout. Results come one per output index as single-cycle strobes;
// the receiver cannot stall. Reset clears control only; the element memory
// is undefined.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4 import mxinv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  element_t element,
	output logic     result_strobe,
	output result_t  result
);

	localparam int DW    = DATA_WIDTH;
	localparam int CW    = 3 * DW + 2;
	localparam int DEW   = 4 * DW + 4;
	localparam int MW    = 2 * DW;
	localparam int NDIG  = (CW + DIG - 1) / DIG;
	localparam int NDEL  = (DW + DIG - 1) / DIG;
	localparam int YW    = NDIG * DIG;
	localparam int CNTW  = $clog2(NDIG);
	localparam int NW    = CW + 2 * FRAC_BITS;
	localparam int QW    = DW + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RA   = 4'd1;
	localparam logic [3:0] S_RB   = 4'd2;
	localparam logic [3:0] S_RC   = 4'd3;
	localparam logic [3:0] S_M1   = 4'd4;
	localparam logic [3:0] S_M1W  = 4'd5;
	localparam logic [3:0] S_M2W  = 4'd6;
	localparam logic [3:0] S_CWR  = 4'd7;
	localparam logic [3:0] S_DRD  = 4'd8;
	localparam logic [3:0] S_DLAT = 4'd9;
	localparam logic [3:0] S_DMW  = 4'd10;
	localparam logic [3:0] S_DCHK = 4'd11;
	localparam logic [3:0] S_QRD  = 4'd12;
	localparam logic [3:0] S_QLAT = 4'd13;
	localparam logic [3:0] S_QDW  = 4'd14;

	logic [3:0]            state_q;
	logic [3:0]            ci_q;
	logic [2:0]            t_q;
	logic [1:0]            dc_q;
	logic [3:0]            k_q;
	logic                  sing_q;
	logic                  neg_q;
	logic                  strobe_q;

	logic [DW-1:0]         store_mem [16];
	logic [DW-1:0]         rdata_q;
	logic [3:0]            raddr;
	logic signed [CW-1:0]  cof_mem [16];
	logic signed [CW-1:0]  cof_rdata_q;
	logic [3:0]            cof_raddr;

	logic [DW-1:0]         a_q;
	logic [DW-1:0]         b_q;
	logic [DW-1:0]         c_q;
	logic signed [CW-1:0]  acc_q;
	logic signed [DEW-1:0] det_q;
	logic [DEW-1:0]        dmag_q;
	result_t               result_q;

	logic [DW-1:0]         a_mag;
	logic [DW-1:0]         b_mag;
	logic [DW-1:0]         c_mag;
	logic [DW-1:0]         rd_mag;
	logic [CW-1:0]         cf_mag;

	logic                  mul_start;
	logic [MW-1:0]         mul_m;
	logic [YW-1:0]         mul_y;
	logic [CNTW-1:0]       mul_top;
	logic                  mul_done;
	logic [MW+YW-1:0]      mul_p;

	logic                  div_start;
	logic                  div_done;
	logic                  div_ovf;
	logic [QW-1:0]         div_q;
	logic [QW-1:0]         limit;
	logic                  sat;
	logic [DW-1:0]         qval;
	logic                  emit;

	assign busy = (state_q != S_IDLE);

	assign a_mag  = a_q[DW-1] ? DW'(-a_q) : a_q;
	assign b_mag  = b_q[DW-1] ? DW'(-b_q) : b_q;
	assign c_mag  = c_q[DW-1] ? DW'(-c_q) : c_q;
	assign rd_mag = rdata_q[DW-1] ? DW'(-rdata_q) : rdata_q;
	assign cf_mag = cof_rdata_q[CW-1] ? CW'(-cof_rdata_q) : CW'(cof_rdata_q);

	always_comb begin
		case (state_q)
			S_RB:    raddr = elem_addr(ci_q, t_q, 2'd1);
			S_RC:    raddr = elem_addr(ci_q, t_q, 2'd2);
			S_DRD:   raddr = {2'b00, dc_q};
			default: raddr = elem_addr(ci_q, t_q, 2'd0);
		endcase
		cof_raddr = (state_q == S_QRD) ? {k_q[1:0], k_q[3:2]} : {2'b00, dc_q};
	end

	// element and cofactor memories
	always_ff @(posedge clk) begin
		if (start && !busy)
			store_mem[element.element_index] <= element.element_value;
		rdata_q <= store_mem[raddr];
		if (state_q == S_CWR)
			cof_mem[ci_q] <= acc_q;
		cof_rdata_q <= cof_mem[cof_raddr];
	end

	always_comb begin
		mul_start = 1'b0;
		mul_m     = MW'(a_mag);
		mul_y     = YW'(b_mag);
		mul_top   = CNTW'(NDEL - 1);
		case (state_q)
			S_M1: begin
				mul_start = 1'b1;
			end
			S_M1W: begin
				mul_start = mul_done;
				mul_m     = mul_p[MW-1:0];
				mul_y     = YW'(c_mag);
			end
			S_DLAT: begin
				mul_start = 1'b1;
				mul_m     = MW'(rd_mag);
				mul_y     = YW'(cf_mag);
				mul_top   = CNTW'(NDIG - 1);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mxinv_mul #(
		.MW   (MW),
		.YW   (YW),
		.CNTW (CNTW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.m       (mul_m),
		.y       (mul_y),
		.top_dig (mul_top),
		.done    (mul_done),
		.p       (mul_p)
	);

	assign div_start = (state_q == S_QLAT) && !sing_q;

	mxinv_div #(
		.NW  (NW),
		.DEW (DEW),
		.QW  (QW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (NW'(cf_mag) << (2 * FRAC_BITS)),
		.den    (dmag_q),
		.done   (div_done),
		.ovf    (div_ovf),
		.quo    (div_q)
	);

	assign limit = neg_q ? (QW'(1) << (DW - 1)) : ((QW'(1) << (DW - 1)) - QW'(1));
	assign sat   = div_ovf || (div_q > limit);
	assign qval  = neg_q ? DW'(-div_q[DW-1:0]) : div_q[DW-1:0];
	assign emit  = ((state_q == S_QLAT) && sing_q) || ((state_q == S_QDW) && div_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ci_q     <= '0;
			t_q      <= '0;
			dc_q     <= '0;
			k_q      <= '0;
			sing_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			case (state_q)
				S_IDLE: begin
					if (start && element.element_index == LAST_INDEX) begin
						state_q <= S_RA;
						ci_q    <= '0;
						t_q     <= '0;
					end
				end
				S_RA:  state_q <= S_RB;
				S_RB:  state_q <= S_RC;
				S_RC:  state_q <= S_M1;
				S_M1:  state_q <= S_M1W;
				S_M1W: begin
					if (mul_done)
						state_q <= S_M2W;
				end
				S_M2W: begin
					if (mul_done) begin
						if (t_q == 3'd5) begin
							state_q <= S_CWR;
						end else begin
							t_q     <= t_q + 3'd1;
							state_q <= S_RA;
						end
					end
				end
				S_CWR: begin
					t_q  <= '0;
					ci_q <= ci_q + 4'd1;
					dc_q <= '0;
					state_q <= (ci_q == LAST_INDEX) ? S_DRD : S_RA;
				end
				S_DRD:  state_q <= S_DLAT;
				S_DLAT: state_q <= S_DMW;
				S_DMW: begin
					if (mul_done) begin
						dc_q    <= dc_q + 2'd1;
						state_q <= (dc_q == 2'd3) ? S_DCHK : S_DRD;
					end
				end
				S_DCHK: begin
					sing_q  <= (det_q == '0);
					k_q     <= '0;
					state_q <= S_QRD;
				end
				S_QRD:  state_q <= S_QLAT;
				S_QLAT: begin
					if (!sing_q)
						state_q <= S_QDW;
				end
				S_QDW:  state_q <= S_QDW;
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit) begin
				k_q     <= k_q + 4'd1;
				state_q <= (k_q == LAST_INDEX) ? S_IDLE : S_QRD;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: acc_q <= '0;
			S_RB:   a_q <= rdata_q;
			S_RC:   b_q <= rdata_q;
			S_M1: begin
				c_q   <= rdata_q;
				neg_q <= a_q[DW-1] ^ b_q[DW-1] ^ rdata_q[DW-1] ^ (t_q >= 3'd3)
					^ ci_q[2] ^ ci_q[0];
			end
			S_M2W: begin
				if (mul_done)
					acc_q <= neg_q ? acc_q - CW'(mul_p) : acc_q + CW'(mul_p);
			end
			S_CWR: begin
				acc_q <= '0;
				det_q <= '0;
			end
			S_DLAT: neg_q <= rdata_q[DW-1] ^ cof_rdata_q[CW-1];
			S_DMW: begin
				if (mul_done)
					det_q <= neg_q ? det_q - DEW'(mul_p) : det_q + DEW'(mul_p);
			end
			S_DCHK: dmag_q <= det_q[DEW-1] ? DEW'(-det_q) : DEW'(det_q);
			S_QLAT: neg_q <= cof_rdata_q[CW-1] ^ det_q[DEW-1];
			default: begin
			end
		endcase
		if (emit) begin
			result_q.out_index   <= k_q;
			result_q.last_result <= (k_q == LAST_INDEX);
			result_q.singular    <= sing_q;
			if (sing_q) begin
				result_q.inverse_value <= '0;
				result_q.saturated     <= 1'b0;
			end else if (sat) begin
				result_q.inverse_value <= neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
				result_q.saturated     <= 1'b1;
			end else begin
				result_q.inverse_value <= qval;
				result_q.saturated     <= 1'b0;
			end
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last_result |-> !busy)
		else $error("busy after last result");

	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && element.element_index != LAST_INDEX |=> !busy)
		else $error("busy after non-final element");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.singular |-> result.inverse_value == '0 && !result.saturated)
		else $error("singular result not zero");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.saturated |->
		result.inverse_value == {1'b1, {(DW-1){1'b0}}} ||
		result.inverse_value == {1'b0, {(DW-1){1'b1}}})
		else $error("saturated value not at a bound");

endmodule

[sim/mxinv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxinv_checker
// Watches the element and result channels of the 4x4 matrix inverse, keeps
// its own copy of the element memory, predicts the sixteen inverse elements
// of every index-15 beat with exact wide arithmetic and compares each whole
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module mxinv_checker import mxinv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  element_t element,
	input  logic     result_strobe,
	input  result_t  result,
	output int       errors,
	output int       pending
);

	typedef logic signed [191:0] wide_t;

	logic [DATA_WIDTH-1:0] shadow_mem [16];
	result_t               inverse_q[$];

	function automatic wide_t widen(input logic [DATA_WIDTH-1:0] v);
		return {{(192-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
	endfunction

	function automatic wide_t minor_cofactor(input int i, input int j);
		wide_t m [3][3];
		wide_t acc;
		int    a;
		int    b;
		a = 0;
		for (int s = 0; s < 4; s++) begin
			if (s != i) begin
				b = 0;
				for (int t = 0; t < 4; t++) begin
					if (t != j) begin
						m[a][b] = widen(shadow_mem[s*4+t]);
						b++;
					end
				end
				a++;
			end
		end
		acc = m[0][0]*m[1][1]*m[2][2] + m[0][1]*m[1][2]*m[2][0] + m[0][2]*m[1][0]*m[2][1]
			- m[0][0]*m[1][2]*m[2][1] - m[0][1]*m[1][0]*m[2][2] - m[0][2]*m[1][1]*m[2][0];
		return ((i + j) % 2 == 1) ? -acc : acc;
	endfunction

	task automatic predict_inverse();
		wide_t            cof [4][4];
		wide_t            det;
		logic [191:0]     dmag;
		logic [191:0]     num;
		logic [191:0]     quo;
		logic [191:0]     limit;
		logic             neg;
		result_t          r;
		det = '0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				cof[i][j] = minor_cofactor(i, j);
		for (int c = 0; c < 4; c++)
			det = det + widen(shadow_mem[c]) * cof[0][c];
		dmag = det[191] ? -det : det;
		for (int k = 0; k < 16; k++) begin
			r = '0;
			r.out_index   = 4'(k);
			r.last_result = (k == 15);
			if (det == 0) begin
				r.singular = 1'b1;
			end else begin
				neg   = cof[k%4][k/4][191] != det[191];
				num   = cof[k%4][k/4][191] ? -cof[k%4][k/4] : cof[k%4][k/4];
				num   = num << (2*FRAC_BITS);
				quo   = num / dmag;
				limit = (192'(1) << (DATA_WIDTH-1)) - (neg ? 0 : 1);
				if (quo > limit) begin
					r.saturated     = 1'b1;
					r.inverse_value = neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
						: {1'b0, {(DATA_WIDTH-1){1'b1}}};
				end else begin
					r.inverse_value = neg ? DATA_WIDTH'(-quo) : DATA_WIDTH'(quo);
				end
			end
			inverse_q.push_back(r);
		end
	endtask

	assign pending = inverse_q.size();

	initial begin
		errors = 0;
		for (int k = 0; k < 16; k++) shadow_mem[k] = '0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_strobe) begin
				if (inverse_q.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, result);
					errors++;
				end else begin
					if (result !== inverse_q[0])
						begin
						$display("%0t: mismatch expected %h actual %h", $time,
							inverse_q[0], result);
						errors++;
					end
					void'(inverse_q.pop_front());
				end
			end
			if (start && !busy) begin
				shadow_mem[element.element_index] = element.element_value;
				if (element.element_index == LAST_INDEX) predict_inverse();
			end
		end
	end

endmodule

[sim/tb_matrix_inverse_4x4.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_4x4
// Stimulus and verdict for the 4x4 matrix inverse: a short directed run on
// identity, singular, saturating and extreme matrices, then random matrices
// loaded in shuffled order with some loose element beats, under phases of
// sender idling. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_4x4;
	import mxinv_pkg::*;

	localparam int ITEMS = 470;
	localparam int LIMIT = 4000000;
	localparam logic [31:0] ONE = 32'h0001_0000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	element_t element;
	logic     result_strobe;
	result_t  result;
	int       errors;
	int       pending;
	int       cycles;
	int       idle_pct;
	int       beats;

	matrix_inverse_4x4 dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .element(element),
		.result_strobe(result_strobe), .result(result)
	);

	mxinv_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .element(element),
		.result_strobe(result_strobe), .result(result), .errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_matrix_inverse_4x4 failed");
			$finish;
		end
	end

	task automatic send_beat(input logic [31:0] v, input logic [3:0] idx);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		element <= '{element_value: v, element_index: idx};
		@(posedge clk);
		while (busy) @(posedge clk);
		beats++;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return 32'($urandom_range(32'h80000)) - 32'h40000;
			1: return $urandom;
			2: case ($urandom_range(4))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0;
				3: return 32'h1;
				default: return 32'hffff_ffff;
			endcase
			default: return ($urandom_range(1) != 0) ? ONE : 32'($urandom_range(255)) - 128;
		endcase
	endfunction

	task automatic load_matrix();
		logic [3:0] order [15];
		logic [3:0] tmp;
		int         j;
		for (int k = 0; k < 15; k++) order[k] = 4'(k);
		for (int k = 14; k > 0; k--) begin
			j        = $urandom_range(k);
			tmp      = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		for (int k = 0; k < 15; k++) send_beat(rand_value(), order[k]);
		send_beat(rand_value(), LAST_INDEX);
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		element  = '0;
		cycles   = 0;
		idle_pct = 0;
		beats    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, then singular, saturating and extreme variants
		for (int k = 0; k < 16; k++) send_beat((k % 5 == 0) ? ONE : 32'h0, 4'(k));
		send_beat(32'h0, LAST_INDEX);
		send_beat(32'h1, 4'd0);
		send_beat(ONE, LAST_INDEX);
		send_beat(32'h8000_0000, 4'd0);
		send_beat(32'h7fff_ffff, LAST_INDEX);
		send_beat(32'hffff_ffff, 4'd5);
		send_beat(32'h8000_0000, LAST_INDEX);
		send_beat(32'hffff_ffff, 4'd0);
		send_beat(32'hffff_ffff, LAST_INDEX);

		while (beats < ITEMS) begin
			case ((beats * 4) / ITEMS)
				0: idle_pct = 0;
				1: idle_pct = 56;
				2: idle_pct = 0;
				default: idle_pct = 11;
			endcase
			if ($urandom_range(9) < 8) begin
				load_matrix();
			end else begin
				repeat ($urandom_range(1, 6))
					send_beat(rand_value(), 4'($urandom_range(15)));
			end
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_matrix_inverse_4x4 passed");
		else
			$display("tb_matrix_inverse_4x4 failed");
		$finish;
	end

endmodule
